// File: rtl/flat_bottom_distance_restraint_macros.svh
// Assertion macros for the flat-bottom distance restraint block.
`ifndef FLAT_BOTTOM_DISTANCE_RESTRAINT_MACROS_SVH
`define FLAT_BOTTOM_DISTANCE_RESTRAINT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define FBDR_CHECK(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("fbdr check failed");
// Check that a condition holds in the cycle after a trigger.
`define FBDR_CHECK_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("fbdr sequence check failed");
`else
`define FBDR_CHECK(label, expr)
`define FBDR_CHECK_NEXT(label, pre, post)
`endif
`endif

// File: rtl/fbdr_pkg.sv
package fbdr_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int ROOT_STEPS    = 35;   // result bits of the square root
   localparam int MUL_DIGIT     = 16;   // multiplier bits consumed per cycle
   localparam int MUL_A_W       = 64;
   localparam int MUL_B_W       = 48;
   localparam int MUL_STEPS     = MUL_B_W / MUL_DIGIT;
   localparam int MUL_P_W       = MUL_A_W + MUL_B_W;
   localparam int CNT_W         = 6;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_LOAD,
      OP_MUL_STEP,
      OP_MUL_STORE,
      OP_ROOT_INIT,
      OP_ROOT_STEP,
      OP_VIOL,
      OP_DIV_STEP,
      OP_OUT
   } fbdr_op_type;

   typedef enum logic [3:0] {
      MJ_SQX,
      MJ_SQY,
      MJ_SQZ,
      MJ_VV,
      MJ_KS,
      MJ_KV,
      MJ_GX,
      MJ_GY,
      MJ_GZ
   } fbdr_job_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_LOAD,
      S_MUL_RUN,
      S_MUL_STORE,
      S_ROOT_INIT,
      S_ROOT,
      S_VIOL,
      S_DIV,
      S_OUT
   } fbdr_state_type;

   typedef struct packed {
      fbdr_op_type  op;
      fbdr_job_type job;
   } fbdr_cmd_type;

   typedef struct packed {
      logic out_free;
   } fbdr_sts_type;

endpackage

// File: rtl/fbdr_ctrl.sv
`include "flat_bottom_distance_restraint_macros.svh"

module fbdr_ctrl import fbdr_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output fbdr_cmd_type cmd,
   input  fbdr_sts_type sts
);

   localparam int DIV_STEPS = FRAC_BITS + 1;

   fbdr_state_type     state_ff, state_in;
   fbdr_job_type       job_ff, job_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // hold state, job and step count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         job_ff   <= MJ_SQX;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         cnt_ff   <= cnt_in;
      end
   end

   // sequence the datapath through squares, root, energy, divide and gradient
   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      cmd.job   = job_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               job_in   = MJ_SQX;
               state_in = S_MUL_LOAD;
            end
         end
         S_MUL_LOAD: begin
            cmd.op   = OP_MUL_LOAD;
            cnt_in   = '0;
            state_in = S_MUL_RUN;
         end
         S_MUL_RUN: begin
            cmd.op = OP_MUL_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
               state_in = S_MUL_STORE;
            end
         end
         S_MUL_STORE: begin
            cmd.op = OP_MUL_STORE;
            unique case (job_ff)
               MJ_SQX: begin
                  job_in   = MJ_SQY;
                  state_in = S_MUL_LOAD;
               end
               MJ_SQY: begin
                  job_in   = MJ_SQZ;
                  state_in = S_MUL_LOAD;
               end
               MJ_SQZ: state_in = S_ROOT_INIT;
               MJ_VV: begin
                  job_in   = MJ_KS;
                  state_in = S_MUL_LOAD;
               end
               MJ_KS: begin
                  job_in   = MJ_KV;
                  state_in = S_MUL_LOAD;
               end
               MJ_KV: begin
                  cnt_in   = '0;
                  state_in = S_DIV;
               end
               MJ_GX: begin
                  job_in   = MJ_GY;
                  state_in = S_MUL_LOAD;
               end
               MJ_GY: begin
                  job_in   = MJ_GZ;
                  state_in = S_MUL_LOAD;
               end
               MJ_GZ: state_in = S_OUT;
               default: state_in = S_IDLE;
            endcase
         end
         S_ROOT_INIT: begin
            cmd.op   = OP_ROOT_INIT;
            cnt_in   = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            cmd.op = OP_ROOT_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) begin
               state_in = S_VIOL;
            end
         end
         S_VIOL: begin
            cmd.op   = OP_VIOL;
            job_in   = MJ_VV;
            state_in = S_MUL_LOAD;
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               job_in   = MJ_GX;
               state_in = S_MUL_LOAD;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.op   = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   `FBDR_CHECK(a_cnt_range, cnt_ff <= CNT_W'(ROOT_STEPS))
   `FBDR_CHECK_NEXT(a_start, req_valid && req_ready, state_ff == S_MUL_LOAD)
   `FBDR_CHECK(a_out_free, cmd.op != OP_OUT || sts.out_free)

endmodule

// File: rtl/fbdr_datapath.sv
`include "flat_bottom_distance_restraint_macros.svh"

module fbdr_datapath import fbdr_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  fbdr_cmd_type        cmd,
   output fbdr_sts_type        sts,
   input  logic [15:0]         req_atom_a,
   input  logic [15:0]         req_atom_b,
   input  logic signed [31:0]  req_ax,
   input  logic signed [31:0]  req_ay,
   input  logic signed [31:0]  req_az,
   input  logic signed [31:0]  req_bx,
   input  logic signed [31:0]  req_by_coord,
   input  logic signed [31:0]  req_bz,
   input  logic [30:0]         req_lower_bound,
   input  logic [30:0]         req_upper_bound,
   input  logic [30:0]         req_spring_k,
   input  logic                req_last_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_atom_a_out,
   output logic [15:0]         rsp_atom_b_out,
   output logic [47:0]         rsp_energy_term,
   output logic [47:0]         rsp_energy_total,
   output logic signed [47:0]  rsp_grad_x,
   output logic signed [47:0]  rsp_grad_y,
   output logic signed [47:0]  rsp_grad_z,
   output logic                rsp_last_out
);

   localparam int R_W = FRAC_BITS + 1;     // gradient ratio, at most 1.0
   localparam int P_W = 64 - FRAC_BITS;    // prefactor, wraps like 64-bit math

   // captured request
   logic [15:0]        atom_a_ff, atom_b_ff;
   logic [32:0]        dm_ff [3];
   logic [2:0]         dneg_ff;
   logic [30:0]        lo_ff, hi_ff, k_ff;
   logic               last_ff;
   // shared multiplier
   logic [MUL_A_W-1:0] ma_ff;
   logic [MUL_B_W-1:0] mb_ff;
   logic [MUL_P_W-1:0] mp_ff;
   // intermediate results
   logic [65:0]        sum_ff;
   logic [69:0]        rad_ff;
   logic [37:0]        rrem_ff;
   logic [34:0]        root_ff;
   logic [34:0]        viol_ff;
   logic               pneg_ff;
   logic [63:0]        sq_ff;
   logic [47:0]        term_ff;
   logic [P_W-1:0]     p_ff;
   logic [34:0]        ddiv_ff;
   logic [34:0]        drem_ff [3];
   logic [R_W-1:0]     q_ff [3];
   logic [46:0]        g_ff [3];
   // energy and output register
   logic [47:0]        esum_ff;
   logic               rsp_valid_ff;
   logic [47:0]        term_out_ff, total_out_ff;
   logic [47:0]        grad_out_ff [3];

   logic [32:0]        d_w [3];
   logic [32:0]        dm_w [3];
   logic [MUL_A_W-1:0] ma_w;
   logic [MUL_B_W-1:0] mb_w;
   logic [37:0]        rrem_sh_w, trial_w;
   logic [MUL_P_W-1:0] term_sh_w, g_sh_w;
   logic [48:0]        total_w;
   logic [47:0]        total_sat_w;

   // take coordinate differences and their magnitudes
   always_comb begin
      d_w[0] = {req_ax[31], req_ax} - {req_bx[31], req_bx};
      d_w[1] = {req_ay[31], req_ay} - {req_by_coord[31], req_by_coord};
      d_w[2] = {req_az[31], req_az} - {req_bz[31], req_bz};
      for (int i = 0; i < 3; i++) begin
         dm_w[i] = d_w[i][32] ? (~d_w[i] + 33'd1) : d_w[i];
      end
   end

   // pick multiplier operands for the job
   always_comb begin
      ma_w = '0;
      mb_w = '0;
      unique case (cmd.job)
         MJ_SQX: begin
            ma_w = MUL_A_W'(dm_ff[0]);
            mb_w = MUL_B_W'(dm_ff[0]);
         end
         MJ_SQY: begin
            ma_w = MUL_A_W'(dm_ff[1]);
            mb_w = MUL_B_W'(dm_ff[1]);
         end
         MJ_SQZ: begin
            ma_w = MUL_A_W'(dm_ff[2]);
            mb_w = MUL_B_W'(dm_ff[2]);
         end
         MJ_VV: begin
            ma_w = MUL_A_W'(viol_ff);
            mb_w = MUL_B_W'(viol_ff);
         end
         MJ_KS: begin
            ma_w = sq_ff;
            mb_w = MUL_B_W'(k_ff);
         end
         MJ_KV: begin
            ma_w = MUL_A_W'(viol_ff);
            mb_w = MUL_B_W'(k_ff);
         end
         MJ_GX: begin
            ma_w = MUL_A_W'(p_ff);
            mb_w = MUL_B_W'(q_ff[0]);
         end
         MJ_GY: begin
            ma_w = MUL_A_W'(p_ff);
            mb_w = MUL_B_W'(q_ff[1]);
         end
         MJ_GZ: begin
            ma_w = MUL_A_W'(p_ff);
            mb_w = MUL_B_W'(q_ff[2]);
         end
         default: ;
      endcase
   end

   // form root trial values, scale products and saturate sums
   always_comb begin
      rrem_sh_w   = {rrem_ff[35:0], rad_ff[69:68]};
      trial_w     = {1'b0, root_ff, 2'b01};
      term_sh_w   = mp_ff >> (FRAC_BITS + 1);
      g_sh_w      = mp_ff >> FRAC_BITS;
      total_w     = {1'b0, esum_ff} + {1'b0, term_ff};
      total_sat_w = total_w[48] ? '1 : total_w[47:0];
   end

   // run the datapath operation
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            atom_a_ff <= req_atom_a;
            atom_b_ff <= req_atom_b;
            for (int i = 0; i < 3; i++) begin
               dm_ff[i]   <= dm_w[i];
               dneg_ff[i] <= d_w[i][32];
            end
            lo_ff   <= req_lower_bound;
            hi_ff   <= req_upper_bound;
            k_ff    <= req_spring_k;
            last_ff <= req_last_in;
         end
         OP_MUL_LOAD: begin
            ma_ff <= ma_w;
            mb_ff <= mb_w;
            mp_ff <= '0;
         end
         OP_MUL_STEP: begin
            mp_ff <= (mp_ff << MUL_DIGIT)
                     + MUL_P_W'(ma_ff * mb_ff[MUL_B_W-1 -: MUL_DIGIT]);
            mb_ff <= mb_ff << MUL_DIGIT;
         end
         OP_MUL_STORE: begin
            case (cmd.job)
               MJ_SQX: sum_ff <= mp_ff[65:0];
               MJ_SQY, MJ_SQZ: sum_ff <= sum_ff + mp_ff[65:0];
               MJ_VV: sq_ff <= mp_ff[FRAC_BITS +: 64];
               MJ_KS: term_ff <= (|term_sh_w[MUL_P_W-1:48]) ? '1 : term_sh_w[47:0];
               MJ_KV: p_ff <= mp_ff[FRAC_BITS +: P_W];
               MJ_GX: g_ff[0] <= (|g_sh_w[MUL_P_W-1:47]) ? '1 : g_sh_w[46:0];
               MJ_GY: g_ff[1] <= (|g_sh_w[MUL_P_W-1:47]) ? '1 : g_sh_w[46:0];
               MJ_GZ: g_ff[2] <= (|g_sh_w[MUL_P_W-1:47]) ? '1 : g_sh_w[46:0];
               default: ;
            endcase
         end
         OP_ROOT_INIT: begin
            rad_ff  <= {4'b0, sum_ff};
            rrem_ff <= '0;
            root_ff <= '0;
         end
         OP_ROOT_STEP: begin
            // one root bit per cycle from two radicand bits
            if (rrem_sh_w >= trial_w) begin
               rrem_ff <= rrem_sh_w - trial_w;
               root_ff <= {root_ff[33:0], 1'b1};
            end else begin
               rrem_ff <= rrem_sh_w;
               root_ff <= {root_ff[33:0], 1'b0};
            end
            rad_ff <= rad_ff << 2;
         end
         OP_VIOL: begin
            // lower bound wins when the bounds are reversed
            if (root_ff < {4'b0, lo_ff}) begin
               viol_ff <= {4'b0, lo_ff} - root_ff;
               pneg_ff <= 1'b1;
            end else if (root_ff > {4'b0, hi_ff}) begin
               viol_ff <= root_ff - {4'b0, hi_ff};
               pneg_ff <= 1'b0;
            end else begin
               viol_ff <= '0;
               pneg_ff <= 1'b0;
            end
            // floor the divisor at one LSB
            ddiv_ff <= (root_ff == '0) ? 35'd1 : root_ff;
            for (int i = 0; i < 3; i++) begin
               drem_ff[i] <= {2'b0, dm_ff[i]};
               q_ff[i]    <= '0;
            end
         end
         OP_DIV_STEP: begin
            // one quotient bit per lane per cycle
            for (int i = 0; i < 3; i++) begin
               if (drem_ff[i] >= ddiv_ff) begin
                  drem_ff[i] <= {drem_ff[i][33:0] - ddiv_ff[33:0], 1'b0};
                  q_ff[i]    <= {q_ff[i][R_W-2:0], 1'b1};
               end else begin
                  drem_ff[i] <= {drem_ff[i][33:0], 1'b0};
                  q_ff[i]    <= {q_ff[i][R_W-2:0], 1'b0};
               end
            end
         end
         OP_OUT: begin
            term_out_ff  <= term_ff;
            total_out_ff <= total_sat_w;
            for (int i = 0; i < 3; i++) begin
               grad_out_ff[i] <= (pneg_ff ^ dneg_ff[i]) ? (48'd0 - {1'b0, g_ff[i]})
                                                       : {1'b0, g_ff[i]};
            end
         end
         default: ;
      endcase
   end

   // hold response valid and the running energy
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         esum_ff      <= '0;
      end else if (cmd.op == OP_OUT) begin
         rsp_valid_ff <= 1'b1;
         esum_ff      <= last_ff ? '0 : total_sat_w;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // echo fields with the response
   logic [15:0] atom_a_out_ff, atom_b_out_ff;
   logic        last_out_ff;
   always_ff @(posedge clock) begin
      if (cmd.op == OP_OUT) begin
         atom_a_out_ff <= atom_a_ff;
         atom_b_out_ff <= atom_b_ff;
         last_out_ff   <= last_ff;
      end
   end

   assign sts.out_free      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_atom_a_out    = atom_a_out_ff;
   assign rsp_atom_b_out    = atom_b_out_ff;
   assign rsp_energy_term   = term_out_ff;
   assign rsp_energy_total  = total_out_ff;
   assign rsp_grad_x        = grad_out_ff[0];
   assign rsp_grad_y        = grad_out_ff[1];
   assign rsp_grad_z        = grad_out_ff[2];
   assign rsp_last_out      = last_out_ff;

   `FBDR_CHECK(a_rsp_src, !$rose(rsp_valid_ff) || $past(cmd.op == OP_OUT))
   `FBDR_CHECK(a_total_ge_term, !rsp_valid_ff || total_out_ff >= term_out_ff)

endmodule

// File: rtl/flat_bottom_distance_restraint.sv
// Channel   Direction  Handshake              Moves
// req_      in         req_valid/req_ready    one restraint request
// rsp_      out        rsp_valid/rsp_ready    energy and gradient result
//
// The 35-step square root and the shared 64x16 multiplier, used nine times
// per request, take up most of the time that a request spends in the block.
// A new request is taken as soon as the previous result is in the output
// register, even while that result still waits for rsp_ready.
// Synchronous active-high reset clears the sequencer, the response valid
// and the running energy total.
module flat_bottom_distance_restraint import fbdr_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [15:0]         req_atom_a,
   input  logic [15:0]         req_atom_b,
   input  logic signed [31:0]  req_ax,
   input  logic signed [31:0]  req_ay,
   input  logic signed [31:0]  req_az,
   input  logic signed [31:0]  req_bx,
   input  logic signed [31:0]  req_by_coord,
   input  logic signed [31:0]  req_bz,
   input  logic [30:0]         req_lower_bound,
   input  logic [30:0]         req_upper_bound,
   input  logic [30:0]         req_spring_k,
   input  logic                req_last_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_atom_a_out,
   output logic [15:0]         rsp_atom_b_out,
   output logic [47:0]         rsp_energy_term,
   output logic [47:0]         rsp_energy_total,
   output logic signed [47:0]  rsp_grad_x,
   output logic signed [47:0]  rsp_grad_y,
   output logic signed [47:0]  rsp_grad_z,
   output logic                rsp_last_out
);

   fbdr_cmd_type cmd;
   fbdr_sts_type sts;

   fbdr_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   fbdr_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_atom_a       (req_atom_a),
      .req_atom_b       (req_atom_b),
      .req_ax           (req_ax),
      .req_ay           (req_ay),
      .req_az           (req_az),
      .req_bx           (req_bx),
      .req_by_coord     (req_by_coord),
      .req_bz           (req_bz),
      .req_lower_bound  (req_lower_bound),
      .req_upper_bound  (req_upper_bound),
      .req_spring_k     (req_spring_k),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_atom_a_out   (rsp_atom_a_out),
      .rsp_atom_b_out   (rsp_atom_b_out),
      .rsp_energy_term  (rsp_energy_term),
      .rsp_energy_total (rsp_energy_total),
      .rsp_grad_x       (rsp_grad_x),
      .rsp_grad_y       (rsp_grad_y),
      .rsp_grad_z       (rsp_grad_z),
      .rsp_last_out     (rsp_last_out)
   );

endmodule

// File: tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC         = 16;
   localparam int NUM_RANDOM   = 1600;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 300;
   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [47:0] MAX47 = 48'h7FFF_FFFF_FFFF;

   typedef struct {
      logic [15:0]        atom_a;
      logic [15:0]        atom_b;
      logic signed [31:0] ax, ay, az, bx, by_coord, bz;
      logic [30:0]        lower_bound;
      logic [30:0]        upper_bound;
      logic [30:0]        spring_k;
      logic               last_in;
   } restraint_t;

   typedef struct {
      logic [15:0] atom_a;
      logic [15:0] atom_b;
      logic [47:0] energy_term;
      logic [47:0] energy_total;
      logic [47:0] grad_x, grad_y, grad_z;
      logic        last_out;
   } restraint_rsp_t;

   // Restraint energy and gradient predictor and queue of expected responses
   class restraint_scoreboard;
      restraint_rsp_t expected_q[$];
      logic [47:0]    energy_sum;
      int             errors;

      function new();
         energy_sum = '0;
         errors     = 0;
      endfunction

      function void report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch %s: got %0h, expected %0h", what, got, want);
         errors++;
      endfunction

      // Predict the response of one accepted request
      function void note_request(restraint_t q);
         logic signed [32:0] dif [3];
         logic [32:0]        dmag [3];
         logic [127:0]       acc, wide;
         logic [63:0]        root, cand, viol, sqv, kv, prefac, ddiv, ratio, g;
         logic [48:0]        tot;
         logic [47:0]        term;
         logic               pneg;
         restraint_rsp_t     e;
         dif[0] = {q.ax[31], q.ax} - {q.bx[31], q.bx};
         dif[1] = {q.ay[31], q.ay} - {q.by_coord[31], q.by_coord};
         dif[2] = {q.az[31], q.az} - {q.bz[31], q.bz};
         acc = '0;
         for (int i = 0; i < 3; i++) begin
            dmag[i] = dif[i][32] ? -dif[i] : dif[i];
            acc = acc + 128'(dmag[i]) * 128'(dmag[i]);
         end
         // bitwise integer square root
         root = '0;
         for (int b = 34; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= acc) root = cand;
         end
         // flat-bottom violation, lower bound tested first
         viol = '0;
         pneg = 1'b0;
         if (root < 64'(q.lower_bound)) begin
            viol = 64'(q.lower_bound) - root;
            pneg = 1'b1;
         end else if (root > 64'(q.upper_bound)) begin
            viol = root - 64'(q.upper_bound);
         end
         wide = (128'(viol) * 128'(viol)) >> FRAC;
         sqv  = (wide[127:64] != 0) ? '1 : wide[63:0];
         wide = (128'(q.spring_k) * 128'(sqv)) >> (FRAC + 1);
         term = (wide > 128'(MAX48)) ? MAX48 : wide[47:0];
         tot  = {1'b0, energy_sum} + {1'b0, term};
         e.atom_a       = q.atom_a;
         e.atom_b       = q.atom_b;
         e.energy_term  = term;
         e.energy_total = tot[48] ? MAX48 : tot[47:0];
         e.last_out     = q.last_in;
         // gradient: prefactor wraps at 64 bits before the shift
         kv     = 64'(q.spring_k) * viol;
         prefac = kv >> FRAC;
         ddiv   = (root != 0) ? root : 64'd1;
         for (int i = 0; i < 3; i++) begin
            ratio = (64'(dmag[i]) << FRAC) / ddiv;
            wide  = (128'(prefac) * 128'(ratio)) >> FRAC;
            g     = (wide > 128'(MAX47)) ? 64'(MAX47) : wide[63:0];
            if (pneg != dif[i][32]) g = -g;
            if (i == 0) e.grad_x = g[47:0];
            else if (i == 1) e.grad_y = g[47:0];
            else e.grad_z = g[47:0];
         end
         energy_sum = q.last_in ? '0 : e.energy_total;
         expected_q.push_back(e);
      endfunction

      // Compare one response with the oldest prediction
      function void check_response(restraint_rsp_t r);
         restraint_rsp_t e;
         if (expected_q.size() == 0) begin
            report("response with nothing expected", 64'(r.atom_a), 64'd0);
            return;
         end
         e = expected_q.pop_front();
         if (r.atom_a != e.atom_a) report("atom_a_out", r.atom_a, e.atom_a);
         if (r.atom_b != e.atom_b) report("atom_b_out", r.atom_b, e.atom_b);
         if (r.energy_term != e.energy_term)
            report("energy_term", r.energy_term, e.energy_term);
         if (r.energy_total != e.energy_total)
            report("energy_total", r.energy_total, e.energy_total);
         if (r.grad_x != e.grad_x) report("grad_x", r.grad_x, e.grad_x);
         if (r.grad_y != e.grad_y) report("grad_y", r.grad_y, e.grad_y);
         if (r.grad_z != e.grad_z) report("grad_z", r.grad_z, e.grad_z);
         if (r.last_out != e.last_out) report("last_out", r.last_out, e.last_out);
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid, req_ready;
   logic [15:0]        req_atom_a, req_atom_b;
   logic signed [31:0] req_ax, req_ay, req_az, req_bx, req_by_coord, req_bz;
   logic [30:0]        req_lower_bound, req_upper_bound, req_spring_k;
   logic               req_last_in;
   logic               rsp_valid, rsp_ready;
   logic [15:0]        rsp_atom_a_out, rsp_atom_b_out;
   logic [47:0]        rsp_energy_term, rsp_energy_total;
   logic signed [47:0] rsp_grad_x, rsp_grad_y, rsp_grad_z;
   logic               rsp_last_out;

   restraint_scoreboard sb = new();
   bit calm;
   int idle_cycles;

   flat_bottom_distance_restraint DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_atom_a(req_atom_a), .req_atom_b(req_atom_b),
      .req_ax(req_ax), .req_ay(req_ay), .req_az(req_az),
      .req_bx(req_bx), .req_by_coord(req_by_coord), .req_bz(req_bz),
      .req_lower_bound(req_lower_bound), .req_upper_bound(req_upper_bound),
      .req_spring_k(req_spring_k), .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_atom_a_out(rsp_atom_a_out), .rsp_atom_b_out(rsp_atom_b_out),
      .rsp_energy_term(rsp_energy_term), .rsp_energy_total(rsp_energy_total),
      .rsp_grad_x(rsp_grad_x), .rsp_grad_y(rsp_grad_y), .rsp_grad_z(rsp_grad_z),
      .rsp_last_out(rsp_last_out)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Note accepted requests
   always @(posedge clock) begin
      restraint_t q;
      if (!reset && req_valid && req_ready) begin
         q.atom_a = req_atom_a;  q.atom_b = req_atom_b;
         q.ax = req_ax;  q.ay = req_ay;  q.az = req_az;
         q.bx = req_bx;  q.by_coord = req_by_coord;  q.bz = req_bz;
         q.lower_bound = req_lower_bound;
         q.upper_bound = req_upper_bound;
         q.spring_k = req_spring_k;
         q.last_in = req_last_in;
         sb.note_request(q);
      end
   end

   // Check responses and stall the response side at random
   always @(posedge clock) begin
      restraint_rsp_t r;
      if (!reset && rsp_valid && rsp_ready) begin
         r.atom_a = rsp_atom_a_out;  r.atom_b = rsp_atom_b_out;
         r.energy_term = rsp_energy_term;
         r.energy_total = rsp_energy_total;
         r.grad_x = rsp_grad_x;  r.grad_y = rsp_grad_y;  r.grad_z = rsp_grad_z;
         r.last_out = rsp_last_out;
         sb.check_response(r);
      end
      rsp_ready <= calm || ($urandom_range(99) >= 15);
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Present one request and hold it until accepted
   task automatic send_restraint(restraint_t q);
      req_valid <= 1'b1;
      req_atom_a <= q.atom_a;  req_atom_b <= q.atom_b;
      req_ax <= q.ax;  req_ay <= q.ay;  req_az <= q.az;
      req_bx <= q.bx;  req_by_coord <= q.by_coord;  req_bz <= q.bz;
      req_lower_bound <= q.lower_bound;
      req_upper_bound <= q.upper_bound;
      req_spring_k <= q.spring_k;
      req_last_in <= q.last_in;
      do @(posedge clock); while (!req_ready);
      // random gap after acceptance
      if (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic restraint_t make_restraint(int unsigned mode);
      restraint_t q;
      int signed  span;
      logic [30:0] b0, b1;
      q.atom_a  = 16'($urandom);
      q.atom_b  = 16'($urandom);
      q.last_in = ($urandom_range(7) == 0);
      if (mode == 0) begin
         // full-range noise
         q.ax = $urandom;  q.ay = $urandom;  q.az = $urandom;
         q.bx = $urandom;  q.by_coord = $urandom;  q.bz = $urandom;
         b0 = 31'($urandom);  b1 = 31'($urandom);
         q.spring_k = 31'($urandom);
      end else begin
         // nearby atoms with bounds around their distance
         span = 1 << $urandom_range(8, 22);
         q.ax = $urandom_range(0, 1 << 24) - (1 << 23);
         q.ay = $urandom_range(0, 1 << 24) - (1 << 23);
         q.az = $urandom_range(0, 1 << 24) - (1 << 23);
         q.bx = q.ax + $urandom_range(0, 2 * span) - span;
         q.by_coord = q.ay + $urandom_range(0, 2 * span) - span;
         q.bz = q.az + $urandom_range(0, 2 * span) - span;
         b0 = 31'($urandom_range(0, 2 * span));
         b1 = 31'($urandom_range(0, 2 * span));
         q.spring_k = 31'($urandom_range(0, 1 << $urandom_range(4, 30)));
      end
      // mostly ordered bounds, some reversed
      if ($urandom_range(9) == 0 || b0 <= b1) begin
         q.lower_bound = b0;  q.upper_bound = b1;
      end else begin
         q.lower_bound = b1;  q.upper_bound = b0;
      end
      return q;
   endfunction

   function automatic restraint_t make_fixed(logic signed [31:0] a, logic signed [31:0] b,
                                             logic [30:0] lo, logic [30:0] hi,
                                             logic [30:0] k, logic last);
      restraint_t q;
      q.atom_a = 16'hFFFF;  q.atom_b = 16'h0000;
      q.ax = a;  q.ay = a;  q.az = a;
      q.bx = b;  q.by_coord = b;  q.bz = b;
      q.lower_bound = lo;  q.upper_bound = hi;  q.spring_k = k;
      q.last_in = last;
      return q;
   endfunction

   initial begin
      restraint_t q;
      localparam logic signed [31:0] SMIN = 32'sh8000_0000;
      localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
      localparam logic [30:0] UMAX = 31'h7FFF_FFFF;
      localparam logic [30:0] ONE  = 31'h0001_0000;
      reset = 1'b1;
      calm = 1'b0;
      req_valid = 1'b0;
      req_atom_a = '0;  req_atom_b = '0;
      req_ax = '0;  req_ay = '0;  req_az = '0;
      req_bx = '0;  req_by_coord = '0;  req_bz = '0;
      req_lower_bound = '0;  req_upper_bound = '0;  req_spring_k = '0;
      req_last_in = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero distance, inside, below, above, extremes, reversed bounds
      send_restraint(make_fixed(0, 0, 0, 0, ONE, 0));
      send_restraint(make_fixed(0, 0, ONE, 2 * ONE, ONE, 0));
      send_restraint(make_fixed(ONE, 0, 0, UMAX, ONE, 0));
      send_restraint(make_fixed(ONE, 0, 3 * ONE, 4 * ONE, 2 * ONE, 0));
      send_restraint(make_fixed(3 * ONE, 0, 0, ONE, 2 * ONE, 1));
      send_restraint(make_fixed(SMAX, SMIN, 0, 0, UMAX, 0));
      send_restraint(make_fixed(SMIN, SMAX, 0, 0, UMAX, 0));
      send_restraint(make_fixed(SMIN, SMAX, UMAX, UMAX, UMAX, 0));
      send_restraint(make_fixed(0, 0, UMAX, UMAX, UMAX, 1));
      send_restraint(make_fixed(ONE, 0, 4 * ONE, ONE, ONE, 0));
      send_restraint(make_fixed(8 * ONE, 0, 4 * ONE, ONE, ONE, 0));
      send_restraint(make_fixed(1, 0, 0, 0, UMAX, 0));
      send_restraint(make_fixed(-1, 0, 5, 7, UMAX, 0));
      send_restraint(make_fixed(SMAX, SMAX, ONE, ONE, 0, 1));
      q = make_fixed(ONE, -ONE, 0, ONE, ONE, 1);
      q.ay = -ONE;  q.by_coord = ONE;  q.bz = 5 * ONE;
      send_restraint(q);

      // random requests, with one idle-free stretch and one full drain
      for (int n = 0; n < NUM_RANDOM; n++) begin
         calm = (n >= 400 && n < 700);
         if (n == 900) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (sb.expected_q.size() != 0) @(posedge clock);
         end
         send_restraint(make_restraint(($urandom_range(99) < 25) ? 0 : 1));
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      // drain outstanding responses
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
